>>> rtl/core/iptf_pkg.sv
// iptf_pkg: shared types and codes for the ip prefix trie filter
// no dependencies; used by iptf_walk and ip_prefix_trie_filter
`timescale 1ns / 1ps
`default_nettype none
package iptf_pkg;
	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_COVERED  = 2'd1;
	localparam logic [1:0] ST_NO_NODES = 2'd2;
	localparam logic [1:0] ST_TOO_LONG = 2'd3;

	localparam logic MODE_INSERT = 1'b0;
	localparam logic MODE_LOOKUP = 1'b1;

	typedef struct packed {
		logic [1:0] status;
		logic       hit;
		logic [31:0] match_data;
	} result_t;
endpackage
`default_nettype wire

>>> rtl/core/iptf_walk.sv
// iptf_walk: node memory and the sequencer that walks, counts and builds trie paths
// depends on iptf_pkg
`timescale 1ns / 1ps
`default_nettype none
module iptf_walk #(
	parameter int NODE_COUNT = 4096,
	parameter int DATA_WIDTH = 32
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        family,
	input  wire logic        start,
	input  wire logic        mode,
	input  wire logic [63:0] addr_hi,
	input  wire logic [63:0] addr_lo,
	input  wire logic [7:0]  plen,
	input  wire logic [31:0] data_in,
	output logic             busy,
	output logic             done,
	output iptf_pkg::result_t res
);
	localparam int AW = $clog2(NODE_COUNT);
	localparam int CW = AW + 1;
	localparam int MW = 2 * AW + 1 + DATA_WIDTH;

	typedef enum logic [6:0] {
		S_IDLE  = 7'b0000001,
		S_FRD   = 7'b0000010,
		S_FCHK  = 7'b0000100,
		S_CRD   = 7'b0001000,
		S_CCHK  = 7'b0010000,
		S_BUILD = 7'b0100000,
		S_LEAF  = 7'b1000000
	} state_t;

	// node word: {leaf, data, right, left}
	logic [MW-1:0] mem [NODE_COUNT];
	logic [MW-1:0] rd_s1;
	logic [AW-1:0] rd_addr;
	logic          wr_en;
	logic [AW-1:0] wr_addr;
	logic [MW-1:0] wr_data;

	state_t        state_q;
	logic          mode_q;
	logic [127:0]  addr_q;
	logic [7:0]    plen_q;
	logic [DATA_WIDTH-1:0] data_q;
	logic [7:0]    idx_q;
	logic [AW-1:0] node_q;
	logic [CW-1:0] nfree_q;
	logic [CW:0]   need_q;
	logic          present_q;
	logic          mall_q;
	logic [DATA_WIDTH-1:0] mall_data_q;
	logic          root_init_q;
	logic          done_q;
	iptf_pkg::result_t res_q;
	// leaf contents patched in the cycle after the link, at the fresh node address
	logic          leaf_fix_q;
	logic [AW-1:0] leaf_addr_q;

	logic [7:0]    width;
	logic          cur_bit;
	logic          r_leaf;
	logic [AW-1:0] r_left, r_right, r_child;
	logic [DATA_WIDTH-1:0] r_data;
	logic [31:0]   data_ext;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_s1 <= mem[rd_addr];
	end

	assign width   = family ? 8'd128 : 8'd32;
	// ipv4 addresses sit in the low 32 bits, shifted up so bit 127 is walked first
	assign cur_bit = addr_q[7'd127 - idx_q[6:0]];
	// root reads as empty until first written
	assign r_left  = root_init_q || node_q != '0 ? rd_s1[AW-1:0] : '0;
	assign r_right = root_init_q || node_q != '0 ? rd_s1[2*AW-1:AW] : '0;
	assign r_data  = rd_s1[MW-2 -: DATA_WIDTH];
	assign r_leaf  = (root_init_q || node_q != '0) && rd_s1[MW-1];
	assign r_child = cur_bit ? r_right : r_left;
	assign rd_addr = node_q;

	generate
		if (DATA_WIDTH >= 32) begin : g_wide
			assign data_ext = r_data[31:0];
		end else begin : g_narrow
			assign data_ext = {{(32 - DATA_WIDTH){1'b0}}, r_data};
		end
	endgenerate

	always_comb begin
		wr_en   = 1'b0;
		wr_addr = node_q;
		wr_data = rd_s1;
		if (state_q == S_BUILD) begin
			wr_en = 1'b1;
			// fresh node, then link it into the parent next cycle via S_LEAF path
			wr_addr = nfree_q[AW-1:0];
			wr_data = '0;
		end else if (state_q == S_LEAF) begin
			wr_en   = 1'b1;
			wr_addr = node_q;
			wr_data = {r_leaf, r_data, r_right, r_left};
			if (cur_bit) begin
				wr_data[2*AW-1:AW] = nfree_q[AW-1:0];
			end else begin
				wr_data[AW-1:0] = nfree_q[AW-1:0];
			end
		end else if (leaf_fix_q) begin
			wr_en   = 1'b1;
			wr_addr = leaf_addr_q;
			wr_data = {1'b1, data_q, {(2*AW){1'b0}}};
		end
	end

	typedef enum logic [3:0] {
		B_ALLOC = 4'b0001,
		B_LINK  = 4'b0010,
		B_READ  = 4'b0100,
		B_WAIT  = 4'b1000
	} bphase_t;
	bphase_t bph_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			nfree_q     <= CW'(1);
			mall_q      <= 1'b0;
			mall_data_q <= '0;
			root_init_q <= 1'b0;
			done_q      <= 1'b0;
			bph_q       <= B_ALLOC;
			idx_q       <= '0;
			node_q      <= '0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (start) begin
						mode_q <= mode;
						addr_q <= family ? {addr_hi, addr_lo} : {addr_lo[31:0], 96'd0};
						plen_q <= plen;
						data_q <= DATA_WIDTH'(data_in);
						idx_q  <= '0;
						node_q <= '0;
						if (mode == iptf_pkg::MODE_INSERT && plen > width) begin
							res_q  <= '{iptf_pkg::ST_TOO_LONG, 1'b0, 32'd0};
							done_q <= 1'b1;
						end else if (mall_q) begin
							res_q <= mode == iptf_pkg::MODE_INSERT ?
								iptf_pkg::result_t'{iptf_pkg::ST_COVERED, 1'b0, 32'd0} :
								iptf_pkg::result_t'{iptf_pkg::ST_OK, 1'b1,
									32'(mall_data_q)};
							done_q <= 1'b1;
						end else begin
							state_q <= S_FRD;
						end
					end
				end
				S_FRD: state_q <= S_FCHK;
				S_FCHK: begin
					if (r_leaf) begin
						res_q <= mode_q == iptf_pkg::MODE_INSERT ?
							iptf_pkg::result_t'{iptf_pkg::ST_COVERED, 1'b0, 32'd0} :
							iptf_pkg::result_t'{iptf_pkg::ST_OK, 1'b1, data_ext};
						done_q  <= 1'b1;
						state_q <= S_IDLE;
					end else if (idx_q == width || r_child == '0) begin
						if (mode_q == iptf_pkg::MODE_LOOKUP) begin
							res_q   <= '{iptf_pkg::ST_OK, 1'b0, 32'd0};
							done_q  <= 1'b1;
							state_q <= S_IDLE;
						end else if (plen_q == 8'd0) begin
							mall_q      <= 1'b1;
							mall_data_q <= data_q;
							res_q       <= '{iptf_pkg::ST_OK, 1'b0, 32'd0};
							done_q      <= 1'b1;
							state_q     <= S_IDLE;
						end else begin
							idx_q     <= '0;
							node_q    <= '0;
							need_q    <= (CW+1)'(1);
							present_q <= 1'b1;
							state_q   <= S_CRD;
						end
					end else begin
						idx_q   <= idx_q + 8'd1;
						node_q  <= r_child;
						state_q <= S_FRD;
					end
				end
				S_CRD: state_q <= S_CCHK;
				S_CCHK: begin
					// count missing path nodes below depth plen-1
					if (idx_q + 8'd1 >= plen_q) begin
						if ({1'b0, nfree_q} + need_q > (CW+1)'(NODE_COUNT)) begin
							res_q   <= '{iptf_pkg::ST_NO_NODES, 1'b0, 32'd0};
							done_q  <= 1'b1;
							state_q <= S_IDLE;
						end else begin
							idx_q   <= '0;
							node_q  <= '0;
							bph_q   <= B_READ;
							state_q <= S_BUILD;
						end
					end else if (!present_q || r_child == '0) begin
						present_q <= 1'b0;
						need_q  <= need_q + (CW+1)'(plen_q - idx_q - 8'd1);
						idx_q   <= plen_q;
					end else begin
						idx_q   <= idx_q + 8'd1;
						node_q  <= r_child;
						state_q <= S_CRD;
					end
				end
				default: ;
			endcase
			if (state_q == S_BUILD || state_q == S_LEAF) begin
				// build sub-sequence: read parent, then either step or allocate and link
				state_q <= S_BUILD;
				case (bph_q)
					B_READ: bph_q <= B_WAIT;
					B_WAIT: begin
						if (idx_q + 8'd1 < plen_q && r_child != '0) begin
							idx_q  <= idx_q + 8'd1;
							node_q <= r_child;
							bph_q  <= B_READ;
						end else begin
							bph_q <= B_ALLOC;
						end
					end
					B_ALLOC: begin
						// fresh node written this cycle; parent word still in rd_s1
						state_q <= S_LEAF;
						bph_q   <= B_LINK;
					end
					B_LINK: begin
						if (node_q == '0) begin
							root_init_q <= 1'b1;
						end
						nfree_q <= nfree_q + CW'(1);
						if (idx_q + 8'd1 >= plen_q) begin
							state_q <= S_IDLE;
							res_q   <= '{iptf_pkg::ST_OK, 1'b0, 32'd0};
							done_q  <= 1'b1;
						end else begin
							idx_q  <= idx_q + 8'd1;
							node_q <= nfree_q[AW-1:0];
							bph_q  <= B_READ;
						end
					end
					default: bph_q <= B_READ;
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			leaf_fix_q  <= 1'b0;
			leaf_addr_q <= '0;
		end else begin
			leaf_fix_q  <= state_q == S_LEAF && idx_q + 8'd1 >= plen_q;
			leaf_addr_q <= nfree_q[AW-1:0];
		end
	end

	assign busy = state_q != S_IDLE || done_q || leaf_fix_q;
	assign done = done_q;
	assign res  = res_q;

	a_onehot: assert property (@(posedge clk) disable iff (!arst_n) $onehot(state_q))
		else $error("walk state not one-hot");
	a_nfree: assert property (@(posedge clk) disable iff (!arst_n)
		nfree_q <= CW'(NODE_COUNT)) else $error("allocator overran pool");
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> state_q == S_IDLE) else $error("result while walking");
endmodule
`default_nettype wire

>>> rtl/core/ip_prefix_trie_filter.sv
// ip_prefix_trie_filter: stream wrapper with output register around the trie walker
// depends on iptf_pkg and iptf_walk
//  channel  | direction | beat contents
//  s_axis   | in        | tuser mode, tdata {entry_data, prefix_length, address_low, address_high}
//  m_axis   | out       | tdata {match_data, hit, status}
//  cfg      | in        | address_family
// one node memory read per trie level in each walk; an insert walks to find, count and build
// reset clears the allocator, the match-all flag and the root, no memory sweep
// a held result blocks the next beat until taken
`timescale 1ns / 1ps
`default_nettype none
module ip_prefix_trie_filter #(
	parameter int NODE_COUNT = 4096,
	parameter int DATA_WIDTH = 32
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         cfg_we,
	input  wire logic         cfg_wdata,
	input  wire logic         s_axis_tvalid,
	output logic              s_axis_tready,
	input  wire logic [167:0] s_axis_tdata, // address_high, address_low, prefix_length, entry_data
	input  wire logic         s_axis_tuser, // mode
	output logic              m_axis_tvalid,
	input  wire logic         m_axis_tready,
	output logic [39:0]       m_axis_tdata  // status, hit, match_data, pad
);
	logic family_q;
	logic busy, done, oval_q;
	iptf_pkg::result_t res;
	logic [34:0] odata_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			family_q <= 1'b0;
			oval_q   <= 1'b0;
			odata_q  <= '0;
		end else begin
			if (cfg_we) begin
				family_q <= cfg_wdata;
			end
			if (done) begin
				oval_q <= 1'b1;
			end else if (m_axis_tready) begin
				oval_q <= 1'b0;
			end
			if (done) begin
				odata_q <= {res.match_data, res.hit, res.status};
			end
		end
	end

	assign s_axis_tready = !busy && !oval_q;
	assign m_axis_tvalid = oval_q;
	assign m_axis_tdata  = {5'd0, odata_q};

	iptf_walk #(.NODE_COUNT(NODE_COUNT), .DATA_WIDTH(DATA_WIDTH)) u_walk (
		.clk(clk), .arst_n(arst_n), .family(family_q),
		.start(s_axis_tvalid && s_axis_tready),
		.mode(s_axis_tuser), .addr_hi(s_axis_tdata[63:0]),
		.addr_lo(s_axis_tdata[127:64]), .plen(s_axis_tdata[135:128]),
		.data_in(s_axis_tdata[167:136]),
		.busy(busy), .done(done), .res(res)
	);

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !oval_q) else $error("result overwritten");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid) else $error("result dropped");
	a_status: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tdata[2] |-> m_axis_tdata[1:0] == iptf_pkg::ST_OK)
		else $error("hit with bad status");
endmodule
`default_nettype wire
